FILE: design/assert_macros.svh
// Assertion macros shared by the checksum block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising clock, off while reset is high
`define PRXC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication
`define PRXC_ASSERT_IMPL(lbl, ante, cons, msg) \
   `PRXC_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define PRXC_ASSERT_NEXT(lbl, ante, cons, msg) \
   `PRXC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: design/prxc_pkg.sv
// Package: types and constants of the rotate-xor packet checksum
package prxc_pkg;

   localparam logic [31:0] SEED_CONST  = 32'hA5A5A5A5;
   localparam logic [31:0] FINAL_CONST = 32'h9E3779B9;
   localparam int unsigned ROT_AMOUNT  = 5;
   localparam int unsigned FOLD_SHIFT  = 16;
   localparam logic [1:0]  LANE_MASK   = 2'b11;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_present;
      logic [15:0] packet_length;
      logic        last_item;
      logic [31:0] expected_sum;
   } req_item_type;

   // Input register contents handed to the core
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

FILE: design/prxc_if.sv
// Interfaces: request and response channels
interface prxc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        byte_present;
   logic [15:0] packet_length;
   logic        last_item;
   logic [31:0] expected_sum;

   modport source (output valid, data_byte, byte_present, packet_length, last_item,
                   expected_sum, input ready);
   modport sink   (input valid, data_byte, byte_present, packet_length, last_item,
                   expected_sum, output ready);
endinterface

interface prxc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sum_value;
   logic        sum_matches;
   logic        length_mismatch;

   modport source (output valid, sum_value, sum_matches, length_mismatch, input ready);
   modport sink   (input valid, sum_value, sum_matches, length_mismatch, output ready);
endinterface

FILE: design/prxc_in_reg.sv
// Input register: captures one request and holds it until the core takes it
module prxc_in_reg (
   input  logic                clock,
   input  logic                reset,
   prxc_req_if.sink            req_ch,
   input  logic                advance,
   output prxc_pkg::stage_type stage
);
   import prxc_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   assign req_ch.ready = !valid_ff || advance;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = load || (valid_ff && !advance);
      item_in  = item_ff;
      if (load) begin
         item_in.data_byte     = req_ch.data_byte;
         item_in.byte_present  = req_ch.byte_present;
         item_in.packet_length = req_ch.packet_length;
         item_in.last_item     = req_ch.last_item;
         item_in.expected_sum  = req_ch.expected_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

FILE: design/prxc_core.sv
// Core: packet state, one-byte checksum update and result register
module prxc_core (
   input  logic                clock,
   input  logic                reset,
   input  prxc_pkg::stage_type stage,
   output logic                advance,
   prxc_rsp_if.source          rsp_ch
);
   import prxc_pkg::*;

   logic [31:0] word_ff, word_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic        in_packet_ff, in_packet_in;
   logic        over_ff, over_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] sum_ff, sum_in;
   logic        match_ff, match_in;
   logic        mism_ff, mism_in;

   logic        first;
   logic [31:0] base_word, mixed, rotated, folded, lane_byte;
   logic [15:0] base_count, base_len, next_count;
   logic        base_over, next_over;
   logic [1:0]  lane;
   logic [31:0] next_word, sum;

   // Last items need the result slot; others always move on
   assign advance = stage.valid &&
                    (!stage.item.last_item || !rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      first      = !in_packet_ff;
      base_word  = first ? (SEED_CONST ^ {16'd0, stage.item.packet_length}) : word_ff;
      base_count = first ? 16'd0 : count_ff;
      base_len   = first ? stage.item.packet_length : length_ff;
      base_over  = first ? 1'b0 : over_ff;

      lane      = base_count[1:0] & LANE_MASK;
      lane_byte = {24'd0, stage.item.data_byte} << {lane, 3'b000};
      mixed     = base_word ^ lane_byte;
      rotated   = (mixed << ROT_AMOUNT) | (mixed >> (32 - ROT_AMOUNT));
      folded    = rotated ^ (rotated >> FOLD_SHIFT);

      next_word  = stage.item.byte_present ? folded : base_word;
      next_count = base_count + {15'd0, stage.item.byte_present};
      next_over  = base_over || (stage.item.byte_present && (base_count == 16'hFFFF));

      sum = next_word ^ FINAL_CONST ^ {16'd0, base_len};

      word_in      = word_ff;
      count_in     = count_ff;
      length_in    = length_ff;
      over_in      = over_ff;
      in_packet_in = in_packet_ff;
      if (advance) begin
         word_in      = next_word;
         count_in     = next_count;
         length_in    = base_len;
         over_in      = next_over;
         in_packet_in = !stage.item.last_item;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      sum_in       = sum_ff;
      match_in     = match_ff;
      mism_in      = mism_ff;
      if (advance && stage.item.last_item) begin
         rsp_valid_in = 1'b1;
         sum_in       = sum;
         match_in     = (sum == stage.item.expected_sum);
         mism_in      = next_over || (next_count != base_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_packet_ff <= in_packet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff   <= word_in;
      count_ff  <= count_in;
      length_ff <= length_in;
      over_ff   <= over_in;
      sum_ff    <= sum_in;
      match_ff  <= match_in;
      mism_ff   <= mism_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.sum_value       = sum_ff;
   assign rsp_ch.sum_matches     = match_ff;
   assign rsp_ch.length_mismatch = mism_ff;

endmodule

FILE: design/packet_rotate_xor_checksum.sv
// A request taken sits in the input register; when the core consumes a last request, its
//    response is loaded into the result register and shown as valid from there.
// Throughput: one request per cycle while no last request waits for the result slot.
// Non-last requests keep flowing while a response waits; a last request waits for the slot.
// Reset (synchronous, active high) empties both registers and returns to awaiting the
//    first request of a packet.
`include "assert_macros.svh"

module packet_rotate_xor_checksum (
   input  logic       clock,
   input  logic       reset,
   prxc_req_if.sink   req_ch,
   prxc_rsp_if.source rsp_ch
);
   import prxc_pkg::*;

   stage_type stage;   // input register contents
   logic      advance; // core consumes the held request this cycle

   // Input register: ready while empty or being drained
   prxc_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   // Core: seeds on the first request of a packet, folds each byte into
   // its lane, rotates by five and xors in the upper half; on the last
   // request it loads the finished checksum and both flags
   prxc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .rsp_ch  (rsp_ch)
   );

   // A new response only follows a last request leaving the input register
   `PRXC_ASSERT_IMPL(a_rsp_from_last, $rose(rsp_ch.valid),
      $past(advance && stage.item.last_item), "response without a last request")

   // Back-pressure on requests only when the input register is occupied
   `PRXC_ASSERT_IMPL(a_stall_full, !req_ch.ready, stage.valid && !advance,
      "request stalled with room in the input register")

   // A held request that is not consumed stays put
   `PRXC_ASSERT_NEXT(a_hold_stage, stage.valid && !advance,
      stage.valid && $stable(stage.item), "held request lost or altered")

endmodule

FILE: verif/prxc_sum_checker.sv
`timescale 1ns / 1ps
// Checksum checker: watches both channels, predicts each packet's response and compares it.
package prxc_tb_pkg;
   import prxc_pkg::*;

   typedef struct packed {
      logic [31:0] sum_value;
      logic        sum_matches;
      logic        length_mismatch;
   } packet_verdict_type;

   // One byte folded into the running word: lane xor, rotate, fold the top half down
   function automatic logic [31:0] absorb_byte(input logic [31:0] word, input logic [7:0] data,
                                               input logic [1:0] lane);
      logic [31:0] mixed;
      mixed = word ^ ({24'h000000, data} << {lane, 3'b000});
      mixed = (mixed << ROT_AMOUNT) | (mixed >> (32 - ROT_AMOUNT));
      return mixed ^ (mixed >> FOLD_SHIFT);
   endfunction
endpackage

module prxc_sum_checker
   import prxc_pkg::*;
   import prxc_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   prxc_req_if         req_mon,
   prxc_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_sums
);

   packet_verdict_type awaited_verdicts[$];
   int unsigned        mismatches = 0;

   // Predicted packet state
   logic [31:0] packet_word;
   logic [15:0] bytes_seen;
   logic [15:0] declared_length;
   logic        packet_open;
   logic        count_wrapped;

   always @(posedge clock) begin
      packet_verdict_type seen;
      packet_verdict_type want;
      logic [31:0]        sum;
      if (reset) begin
         packet_word     = '0;
         bytes_seen      = '0;
         declared_length = '0;
         packet_open     = 1'b0;
         count_wrapped   = 1'b0;
         awaited_verdicts.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.sum_value, rsp_mon.sum_matches, rsp_mon.length_mismatch};
            if (awaited_verdicts.size() == 0) begin
               $display("%0t: response with none awaited: sum %h match %b len %b",
                        $time, seen.sum_value, seen.sum_matches, seen.length_mismatch);
               mismatches++;
            end else begin
               want = awaited_verdicts.pop_front();
               if (seen.sum_value !== want.sum_value) begin
                  $display("%0t: sum_value expected %h, got %h",
                           $time, want.sum_value, seen.sum_value);
                  mismatches++;
               end
               if (seen.sum_matches !== want.sum_matches) begin
                  $display("%0t: sum_matches expected %b, got %b",
                           $time, want.sum_matches, seen.sum_matches);
                  mismatches++;
               end
               if (seen.length_mismatch !== want.length_mismatch) begin
                  $display("%0t: length_mismatch expected %b, got %b",
                           $time, want.length_mismatch, seen.length_mismatch);
                  mismatches++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (!packet_open) begin
               declared_length = req_mon.packet_length;
               packet_word     = SEED_CONST ^ {16'h0000, req_mon.packet_length};
               bytes_seen      = '0;
               count_wrapped   = 1'b0;
               packet_open     = 1'b1;
            end
            if (req_mon.byte_present) begin
               packet_word = absorb_byte(packet_word, req_mon.data_byte,
                                         bytes_seen[1:0] & LANE_MASK);
               if (bytes_seen == 16'hFFFF)
                  count_wrapped = 1'b1;
               bytes_seen = bytes_seen + 16'd1;
            end
            if (req_mon.last_item) begin
               sum = packet_word ^ FINAL_CONST ^ {16'h0000, declared_length};
               awaited_verdicts.push_back('{sum, sum == req_mon.expected_sum,
                                            count_wrapped || (bytes_seen != declared_length)});
               packet_open = 1'b0;
            end
         end
      end
      fail_count   <= mismatches;
      pending_sums <= awaited_verdicts.size();
   end

endmodule

FILE: verif/packet_rotate_xor_checksum_tb.sv
`timescale 1ns / 1ps
// Testbench top: packet stimulus, response back-pressure, watchdog and verdict.
module packet_rotate_xor_checksum_tb;
   import prxc_pkg::*;
   import prxc_tb_pkg::*;

   // Cycles without any handshake before the run is declared hung
   localparam int unsigned STALL_LIMIT    = 5000;
   localparam int unsigned RANDOM_PER_SET = 533;

   logic clock = 1'b0;
   logic reset;

   prxc_req_if req_ch ();
   prxc_rsp_if rsp_ch ();

   int unsigned fail_count;
   int unsigned pending_sums;
   int unsigned requests_sent = 0;
   int unsigned stall_cycles  = 0;

   // Idle percentages; changed per phase by the stimulus
   int unsigned send_gap_pct = 26;
   int unsigned rcv_gap_pct  = 73;

   packet_rotate_xor_checksum uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   prxc_sum_checker sum_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .pending_sums (pending_sums)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: ready drawn afresh each cycle, low for rcv_gap_pct of them
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_gap_pct);
      end
   end

   // Watchdog: any handshake on either side clears the count
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Presents one request, possibly after idle cycles, and returns at the edge that takes it.
   // Valid stays high on return so back-to-back requests need no second assignment.
   task automatic offer_request(input logic [7:0] data, input logic present,
                                input logic [15:0] length, input logic last,
                                input logic [31:0] sum);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= data;
      req_ch.byte_present  <= present;
      req_ch.packet_length <= length;
      req_ch.last_item     <= last;
      req_ch.expected_sum  <= sum;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      requests_sent++;
   endtask

   // One packet of n_bytes payload bytes declared as 'declared'.
   // fill < 0 gives random bytes, otherwise every byte is fill.
   // hole_pct: chance of a byteless request before each byte, and of a byteless closing request.
   // want_match: the closing request carries the correct checksum rather than a random one.
   task automatic send_packet(input int unsigned n_bytes, input logic [15:0] declared,
                              input int fill, input int unsigned hole_pct,
                              input bit want_match);
      logic [31:0] word;
      logic [31:0] final_sum;
      logic [7:0]  data;
      bit          first;
      bit          tail_hole;
      bit          is_last;
      int unsigned sent;
      word      = SEED_CONST ^ {16'h0000, declared};
      final_sum = word ^ FINAL_CONST ^ {16'h0000, declared};
      first     = 1'b1;
      // an empty packet is always a single byteless closing request
      tail_hole = (n_bytes == 0) || ($urandom_range(0, 99) < hole_pct);
      for (sent = 0; sent < n_bytes; sent++) begin
         if ($urandom_range(0, 99) < hole_pct) begin
            // byteless request mid-packet: data and length must be ignored
            offer_request(8'($urandom), 1'b0, first ? declared : 16'($urandom), 1'b0,
                          $urandom);
            first = 1'b0;
         end
         data      = (fill < 0) ? 8'($urandom) : 8'(fill);
         word      = absorb_byte(word, data, 2'(sent));
         final_sum = word ^ FINAL_CONST ^ {16'h0000, declared};
         is_last   = (sent + 1 == n_bytes) && !tail_hole;
         offer_request(data, 1'b1, first ? declared : 16'($urandom), is_last,
                       (is_last && want_match) ? final_sum : $urandom);
         first = 1'b0;
      end
      if (tail_hole)
         offer_request(8'($urandom), 1'b0, first ? declared : 16'($urandom), 1'b1,
                       want_match ? final_sum : $urandom);
   endtask

   // Holds the request side quiet until every predicted response has been taken
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_sums != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned send_gaps[3];
      int unsigned rcv_gaps[3];
      int unsigned n_bytes;
      int unsigned pick;
      logic [15:0] declared;
      send_gaps = '{26, 73, 0};
      rcv_gaps  = '{73, 26, 0};

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.data_byte     <= '0;
      req_ch.byte_present  <= 1'b0;
      req_ch.packet_length <= '0;
      req_ch.last_item     <= 1'b0;
      req_ch.expected_sum  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed packets
      send_packet(0, 16'h0000, -1, 0, 1'b1);      // empty packet, length agrees
      send_packet(0, 16'hFFFF, -1, 0, 1'b0);      // empty packet, declared maximum
      send_packet(1, 16'h0001, 8'hFF, 0, 1'b1);
      send_packet(4, 16'h0004, 8'h00, 0, 1'b1);   // all four lanes, zero bytes
      send_packet(5, 16'h0005, 8'hFF, 50, 1'b0);  // byteless requests inside the packet
      send_packet(3, 16'h0004, -1, 0, 1'b1);      // fewer bytes than declared
      send_packet(2, 16'h0001, -1, 0, 1'b0);      // more bytes than declared
      send_packet(3, 16'h8000, -1, 100, 1'b1);    // hole before every byte, byteless close

      // Random packets: three idling regimes, each drained before the next
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = send_gaps[phase];
         rcv_gap_pct  = rcv_gaps[phase];
         while (requests_sent < 25 + (phase + 1) * RANDOM_PER_SET) begin
            // mostly short packets, now and then a longer one
            n_bytes = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12)
                                                  : $urandom_range(13, 40);
            pick = $urandom_range(0, 9);
            if (pick < 7)
               declared = 16'(n_bytes);
            else if (pick == 7)
               declared = $urandom_range(0, 1) ? 16'(n_bytes + 1) : 16'(n_bytes - 1);
            else if (pick == 8)
               declared = 16'($urandom);
            else
               declared = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            send_packet(n_bytes, declared, -1,
                        ($urandom_range(0, 3) == 0) ? 25 : 0, $urandom_range(0, 1));
         end
         pause_until_drained();
      end

      pause_until_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
